// ----- hw/rtl/dwm_pkg.sv -----
// Package for the deadline weighted matcher.
// Holds the request and result item types, entry types, codes and the engine states.
// Depends on nothing.
package dwm_pkg;

   localparam logic [1:0] ACT_SEEKER = 2'd0;
   localparam logic [1:0] ACT_DONOR  = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;
   localparam logic [1:0] ACT_WEIGHT = 2'd3;

   localparam logic [1:0] KIND_MATCHED   = 2'd0;
   localparam logic [1:0] KIND_UNMATCHED = 2'd1;
   localparam logic [1:0] KIND_REJECTED  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] item_id;
      logic [2:0]  item_type;
      logic [2:0]  partner_type;
      logic [15:0] deadline;
      logic [7:0]  weight;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] seeker_ref;
      logic [15:0] donor_ref;
      logic [15:0] wait_time;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [2:0]  stype;
      logic [15:0] deadline;
      logic [15:0] arrival;
   } seeker_entry_type;

   typedef struct packed {
      logic [15:0] id;
      logic [2:0]  dtype;
      logic [15:0] deadline;
   } donor_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REJECT,
      ST_SCAN,
      ST_SEARCH,
      ST_EMIT,
      ST_PURGE,
      ST_FLUSH
   } state_type;

endpackage

// ----- hw/rtl/dwm_fifo.sv -----
// Small register queue used between the front and back parts and on the result side.
// Generic in width and depth; no package dependency.
module dwm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hw/rtl/dwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module dwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ----- hw/rtl/dwm_engine.sv -----
// Back part of the matcher: stores, weight table, tick scan and donor search.
// Depends on dwm_pkg and dwm_ram.
module dwm_engine #(
   parameter int SEEKER_SLOTS = 16,
   parameter int DONOR_SLOTS  = 16,
   parameter int TYPE_COUNT   = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  dwm_pkg::req_type cmd_data,
   input  logic            cmd_empty,
   output logic            cmd_pop,
   output dwm_pkg::rsp_type out_data,
   input  logic            out_full,
   output logic            out_push
);
   import dwm_pkg::*;

   localparam int SIW = (SEEKER_SLOTS > 1) ? $clog2(SEEKER_SLOTS) : 1;
   localparam int SCW = $clog2(SEEKER_SLOTS + 1);
   localparam int DIW = (DONOR_SLOTS > 1) ? $clog2(DONOR_SLOTS) : 1;
   localparam int DCW = $clog2(DONOR_SLOTS + 1);
   localparam int WD  = TYPE_COUNT * TYPE_COUNT;
   localparam int AW  = (WD > 1) ? $clog2(WD) : 1;

   state_type        state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [15:0]      tick_ff, tick_in;
   logic [SCW-1:0]   scnt_ff, scnt_in, sidx_ff, sidx_in;
   logic [DCW-1:0]   dcnt_ff, dcnt_in, didx_ff, didx_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [DIW-1:0]   cmp_idx_ff, cmp_idx_in, best_ff, best_in;
   logic [15:0]      cmp_id_ff, cmp_id_in, best_id_ff, best_id_in;
   logic [7:0]       bw_ff, bw_in;
   logic             found_ff, found_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic             rd_valid_ff;
   logic             wvalid_ff [WD];
   seeker_entry_type seek_ff [SEEKER_SLOTS];
   donor_entry_type  don_ff [DONOR_SLOTS];

   seeker_entry_type cur_s;
   donor_entry_type  cur_d;
   logic [15:0]      dl_clamp;
   logic             s_wr, s_rm, d_wr, d_rm;
   logic [DIW-1:0]   d_rm_idx;
   logic             w_we, w_ok, r_ok;
   logic [AW-1:0]    waddr, raddr;
   logic [7:0]       rdata, cmp_w;

   assign cur_s    = seek_ff[sidx_ff[SIW-1:0]];
   assign cur_d    = don_ff[didx_ff[DIW-1:0]];
   assign dl_clamp = (cmd_ff.deadline < tick_ff) ? tick_ff : cmd_ff.deadline;

   // Weight index is donor type times the type count plus seeker type.
   assign w_ok  = (int'(cmd_ff.item_type) < TYPE_COUNT) && (int'(cmd_ff.partner_type) < TYPE_COUNT);
   assign waddr = AW'(int'(cmd_ff.item_type) * TYPE_COUNT + int'(cmd_ff.partner_type));
   assign r_ok  = (int'(cur_d.dtype) < TYPE_COUNT) && (int'(cur_s.stype) < TYPE_COUNT);
   assign raddr = AW'(int'(cur_d.dtype) * TYPE_COUNT + int'(cur_s.stype));
   assign cmp_w = rd_valid_ff ? rdata : 8'd0;

   dwm_ram #(
      .WIDTH(8),
      .DEPTH(WD)
   ) u_weights (
      .clock(clock),
      .we   (w_we),
      .waddr(waddr),
      .wdata(cmd_ff.weight),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tick_in       = tick_ff;
      scnt_in       = scnt_ff;
      sidx_in       = sidx_ff;
      dcnt_in       = dcnt_ff;
      didx_in       = didx_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      cmp_id_in     = cmp_id_ff;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      bw_in         = bw_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_data      = pend_ff;
      s_wr          = 1'b0;
      s_rm          = 1'b0;
      d_wr          = 1'b0;
      d_rm          = 1'b0;
      d_rm_idx      = best_ff;
      w_we          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff.action)
               ACT_SEEKER: begin
                  if (scnt_ff == SCW'(SEEKER_SLOTS)) begin
                     state_in = ST_REJECT;
                  end else begin
                     s_wr     = 1'b1;
                     scnt_in  = scnt_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               ACT_DONOR: begin
                  if (dcnt_ff == DCW'(DONOR_SLOTS)) begin
                     state_in = ST_REJECT;
                  end else begin
                     d_wr     = 1'b1;
                     dcnt_in  = dcnt_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               ACT_TICK: begin
                  sidx_in  = '0;
                  state_in = ST_SCAN;
               end
               default: begin
                  w_we     = w_ok;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_REJECT: begin
            if (!out_full) begin
               out_push            = 1'b1;
               out_data.kind       = KIND_REJECTED;
               out_data.seeker_ref = cmd_ff.item_id;
               out_data.donor_ref  = '0;
               out_data.wait_time  = '0;
               out_data.last       = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (sidx_ff == scnt_ff) begin
               didx_in  = '0;
               state_in = ST_PURGE;
            end else if (cur_s.deadline == tick_ff) begin
               didx_in  = '0;
               bw_in    = '0;
               found_in = 1'b0;
               state_in = ST_SEARCH;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            // One donor enters the weight lookup each cycle; the compare works on the registered weight read.
            if (didx_ff < dcnt_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = didx_ff[DIW-1:0];
               cmp_id_in    = cur_d.id;
               didx_in      = didx_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_EMIT;
            end
            if (cmp_valid_ff && (cmp_w > bw_ff)) begin
               bw_in      = cmp_w;
               best_in    = cmp_idx_ff;
               best_id_in = cmp_id_ff;
               found_in   = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!(pend_valid_ff && out_full)) begin
               out_push           = pend_valid_ff;
               pend_valid_in      = 1'b1;
               pend_in.kind       = found_ff ? KIND_MATCHED : KIND_UNMATCHED;
               pend_in.seeker_ref = cur_s.id;
               pend_in.donor_ref  = found_ff ? best_id_ff : 16'd0;
               pend_in.wait_time  = tick_ff - cur_s.arrival;
               pend_in.last       = 1'b0;
               s_rm               = 1'b1;
               scnt_in            = scnt_ff - 1'b1;
               if (found_ff) begin
                  d_rm    = 1'b1;
                  dcnt_in = dcnt_ff - 1'b1;
               end
               state_in = ST_SCAN;
            end
         end
         ST_PURGE: begin
            if (didx_ff == dcnt_ff) begin
               tick_in  = tick_ff + 1'b1;
               state_in = ST_FLUSH;
            end else if (cur_d.deadline == tick_ff) begin
               d_rm     = 1'b1;
               d_rm_idx = didx_ff[DIW-1:0];
               dcnt_in  = dcnt_ff - 1'b1;
            end else begin
               didx_in = didx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_full) begin
               out_push      = 1'b1;
               out_data.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         scnt_ff       <= '0;
         dcnt_ff       <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         for (int k = 0; k < WD; k++) begin
            wvalid_ff[k] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         scnt_ff       <= scnt_in;
         dcnt_ff       <= dcnt_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (w_we) begin
            wvalid_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sidx_ff     <= sidx_in;
      didx_ff     <= didx_in;
      cmp_idx_ff  <= cmp_idx_in;
      cmp_id_ff   <= cmp_id_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      bw_ff       <= bw_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      rd_valid_ff <= wvalid_ff[raddr] && r_ok;
   end

   // Stores stay in arrival order: a removal shifts every later entry down by one.
   for (genvar k = 0; k < SEEKER_SLOTS; k++) begin : g_seek
      always_ff @(posedge clock) begin
         if (s_wr && (scnt_ff[SIW-1:0] == SIW'(k))) begin
            seek_ff[k] <= '{id: cmd_ff.item_id, stype: cmd_ff.item_type,
                            deadline: dl_clamp, arrival: tick_ff};
         end else if (s_rm && (SCW'(k) >= sidx_ff)) begin
            if (k < SEEKER_SLOTS - 1) begin
               seek_ff[k] <= seek_ff[(k < SEEKER_SLOTS - 1) ? k + 1 : k];
            end
         end
      end
   end

   for (genvar k = 0; k < DONOR_SLOTS; k++) begin : g_don
      always_ff @(posedge clock) begin
         if (d_wr && (dcnt_ff[DIW-1:0] == DIW'(k))) begin
            don_ff[k] <= '{id: cmd_ff.item_id, dtype: cmd_ff.item_type, deadline: dl_clamp};
         end else if (d_rm && (DIW'(k) >= d_rm_idx)) begin
            if (k < DONOR_SLOTS - 1) begin
               don_ff[k] <= don_ff[(k < DONOR_SLOTS - 1) ? k + 1 : k];
            end
         end
      end
   end

endmodule

// ----- hw/rtl/deadline_weighted_matcher_top.sv -----
// An arrival or weight write is taken from the front queue in the idle state and stored in
// the execute state, or a rejection is pushed from the reject state. A tick scans waiting
// seekers, searches the waiting donors for each due seeker (one donor per cycle), emits its
// result, then purges due donors. The back part takes one item at a time; a two-item queue
// lets the front keep accepting, and results leave through a four-item queue. Synchronous
// active-high reset empties both stores, clears all weights and the tick; ready the cycle after.
module deadline_weighted_matcher_top #(
   parameter int SEEKER_SLOTS = 16,
   parameter int DONOR_SLOTS  = 16,
   parameter int TYPE_COUNT   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dwm_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output dwm_pkg::rsp_type rsp_data
);
   import dwm_pkg::*;

   req_type cmd_data;
   rsp_type out_data;
   logic    cmd_empty, cmd_pop, out_full, out_push;

   dwm_fifo #(
      .WIDTH($bits(req_type)),
      .DEPTH(2)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push (push),
      .din  (req_data),
      .full (full),
      .pop  (cmd_pop),
      .dout (cmd_data),
      .empty(cmd_empty)
   );

   dwm_engine #(
      .SEEKER_SLOTS(SEEKER_SLOTS),
      .DONOR_SLOTS (DONOR_SLOTS),
      .TYPE_COUNT  (TYPE_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd_data (cmd_data),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .out_data (out_data),
      .out_full (out_full),
      .out_push (out_push)
   );

   dwm_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(4)
   ) u_results (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .din  (out_data),
      .full (out_full),
      .pop  (pop),
      .dout (rsp_data),
      .empty(empty)
   );

endmodule

// ----- hw/rtl/dwm_checker.sv -----
// Port-level checker for the matcher top level, with its bind statement.
// Depends on dwm_pkg.
module dwm_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input dwm_pkg::rsp_type rsp_data
);
   import dwm_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !full)
      else $error("input side full after reset");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.kind == KIND_MATCHED || rsp_data.kind == KIND_UNMATCHED ||
                  rsp_data.kind == KIND_REJECTED))
      else $error("undefined result kind");

   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_REJECTED) |->
      (rsp_data.donor_ref == 16'd0 && rsp_data.wait_time == 16'd0 && rsp_data.last))
      else $error("malformed rejected item");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind deadline_weighted_matcher_top dwm_checker u_checker (
   .clock   (clock),
   .reset   (reset),
   .full    (full),
   .empty   (empty),
   .pop     (pop),
   .rsp_data(rsp_data)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for deadline_weighted_matcher_top.
// Predicts matcher results in a small scoreboard class and compares each popped item.
// Depends on dwm_pkg and the matcher RTL.
`timescale 1ns / 100ps

module testbench;
   import dwm_pkg::*;

   localparam int SEEKERS   = 16;
   localparam int DONORS    = 16;
   localparam int TYPES     = 8;
   localparam int MAX_CYCLE = 1500000;

   class match_board;
      logic [15:0] now_tick;
      seeker_entry_type seekers[$];
      donor_entry_type donors[$];
      logic [7:0] weights[TYPES*TYPES];
      rsp_type pending[$];
      int errors;
      int checked;

      function void clear();
         now_tick = 0;
         seekers.delete();
         donors.delete();
         pending.delete();
         foreach (weights[i]) weights[i] = 0;
      endfunction

      function void add_result(logic [1:0] kind, logic [15:0] sid, logic [15:0] did,
                               logic [15:0] waited);
         rsp_type r;
         r.kind = kind; r.seeker_ref = sid; r.donor_ref = did;
         r.wait_time = waited; r.last = 1'b0;
         pending.insert(pending.size(), r);
      endfunction

      // Works out the results of one accepted item and updates the state.
      function void note_item(req_type q);
         seeker_entry_type s, kept[$];
         donor_entry_type d, dkept[$];
         logic [15:0] dl;
         int produced, best, bw, pw;
         produced = 0;
         dl = (q.deadline < now_tick) ? now_tick : q.deadline;
         case (q.action)
            ACT_SEEKER: begin
               if (seekers.size() >= SEEKERS) begin
                  add_result(KIND_REJECTED, q.item_id, 0, 0);
                  produced = 1;
               end else begin
                  s.id = q.item_id; s.stype = q.item_type;
                  s.deadline = dl; s.arrival = now_tick;
                  seekers.insert(seekers.size(), s);
               end
            end
            ACT_DONOR: begin
               if (donors.size() >= DONORS) begin
                  add_result(KIND_REJECTED, q.item_id, 0, 0);
                  produced = 1;
               end else begin
                  d.id = q.item_id; d.dtype = q.item_type; d.deadline = dl;
                  donors.insert(donors.size(), d);
               end
            end
            ACT_TICK: begin
               foreach (seekers[i]) begin
                  s = seekers[i];
                  if (s.deadline == now_tick) begin
                     best = 0; bw = 0;
                     foreach (donors[j]) begin
                        pw = weights[donors[j].dtype*TYPES + s.stype];
                        if (pw > bw) begin
                           bw = pw; best = j;
                        end
                     end
                     if (bw > 0) begin
                        add_result(KIND_MATCHED, s.id, donors[best].id, now_tick - s.arrival);
                        donors.delete(best);
                     end else begin
                        add_result(KIND_UNMATCHED, s.id, 0, now_tick - s.arrival);
                     end
                     produced++;
                  end else begin
                     kept.insert(kept.size(), s);
                  end
               end
               seekers = kept;
               foreach (donors[j])
                  if (donors[j].deadline != now_tick) dkept.insert(dkept.size(), donors[j]);
               donors = dkept;
               now_tick = now_tick + 16'd1;
            end
            default: weights[q.item_type*TYPES + q.partner_type] = q.weight;
         endcase
         if (produced > 0) pending[$].last = 1'b1;
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_error("result with nothing expected", got, got);
            return;
         end
         want = pending.pop_front();
         if (got.kind != want.kind) report_error("kind", got, want);
         if (got.seeker_ref != want.seeker_ref) report_error("seeker_ref", got, want);
         if (got.donor_ref != want.donor_ref) report_error("donor_ref", got, want);
         if (got.wait_time != want.wait_time) report_error("wait_time", got, want);
         if (got.last != want.last) report_error("last", got, want);
      endtask

      task report_error(string what, rsp_type got, rsp_type want);
         errors++;
         if (errors <= 40)
            $display("mismatch in %s: got %h expected %h", what, got, want);
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   match_board board;
   int send_idle;
   int recv_idle;
   int cycle_count;
   int items_sent;

   deadline_weighted_matcher_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   initial begin
      board = new();
      board.clear();
      board.errors = 0;
      board.checked = 0;
   end

   // Sampling and checking at the edge itself; inputs change only by nonblocking assignment.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (push && !full) board.note_item(req_data);
         if (pop && !empty) board.check_result(rsp_data);
         pop <= ($urandom_range(99) >= recv_idle);
      end
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Leaves push high after the accepting edge so that items can follow back to back.
   task automatic send_item(req_type q);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   function automatic req_type make_item(logic [1:0] act, logic [15:0] id, logic [2:0] ty,
                                         logic [2:0] pt, logic [15:0] dl, logic [7:0] w);
      req_type q;
      q.action = act; q.item_id = id; q.item_type = ty;
      q.partner_type = pt; q.deadline = dl; q.weight = w;
      return q;
   endfunction

   task automatic random_item();
      int r;
      logic [15:0] dl;
      r = $urandom_range(99);
      dl = 16'(board.now_tick + $urandom_range(4));
      if ($urandom_range(19) == 0) dl = 16'($urandom);
      if (r < 35)
         send_item(make_item(ACT_SEEKER, 16'($urandom), 3'($urandom), 3'($urandom), dl,
                             8'($urandom)));
      else if (r < 70)
         send_item(make_item(ACT_DONOR, 16'($urandom), 3'($urandom), 3'($urandom), dl,
                             8'($urandom)));
      else if (r < 90)
         send_item(make_item(ACT_TICK, 16'($urandom), 3'($urandom), 3'($urandom),
                             16'($urandom), 8'($urandom)));
      else
         send_item(make_item(ACT_WEIGHT, 16'($urandom), 3'($urandom), 3'($urandom),
                             16'($urandom), ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom)));
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      items_sent = 0;
      send_idle = 10;
      recv_idle = 65;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tick with nothing due, seekers with no compatible donor, ties, full stores.
      send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_SEEKER, 16'hffff, 3'd7, 3'd7, 16'h0000, 8'hff));
      send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_WEIGHT, 0, 3'd2, 3'd5, 0, 8'd9));
      send_item(make_item(ACT_WEIGHT, 0, 3'd7, 3'd0, 0, 8'hff));
      send_item(make_item(ACT_DONOR, 16'h0011, 3'd2, 0, 16'd5, 0));
      send_item(make_item(ACT_DONOR, 16'h0022, 3'd2, 0, 16'd5, 0));
      send_item(make_item(ACT_DONOR, 16'h0033, 3'd7, 0, 16'hffff, 0));
      send_item(make_item(ACT_SEEKER, 16'h0001, 3'd5, 0, 16'd3, 0));
      send_item(make_item(ACT_SEEKER, 16'h0002, 3'd0, 0, 16'd3, 0));
      send_item(make_item(ACT_SEEKER, 16'h0003, 3'd5, 0, 16'd3, 0));
      send_item(make_item(ACT_SEEKER, 16'h0004, 3'd1, 0, 16'd3, 0));
      send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      for (int i = 0; i < 17; i++)
         send_item(make_item(ACT_SEEKER, 16'(16'h0100 + i), 3'd5, 0, 16'd4, 0));
      for (int i = 0; i < 17; i++)
         send_item(make_item(ACT_DONOR, 16'(16'h0200 + i), 3'd2, 0, 16'd3, 0));
      send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 10 : (phase == 1) ? 65 : 0;
         recv_idle = (phase == 0) ? 65 : (phase == 1) ? 10 : 0;
         repeat (60) random_item();
      end
      for (int i = 0; i < 6; i++)
         send_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d items through seeker, donor, tick and weight actions;", items_sent);
      $display("checked %0d results under three idling mixes.", board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
